/* rtl/core/bosr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bosr_pkg - shared types and constants of the stroke realigner
// Counter widths, register map, queue entry format and back-end states.
// ----------------------------------------------------------------------------
package bosr_pkg;

	// pixel count width; width_pixels is truncated to this many bits
	localparam int WIDTH_COUNT_BITS = 16;
	// stroke length in bits: up to 4 bits per pixel
	localparam int BITS_W = WIDTH_COUNT_BITS + 2;
	// byte counters: room for the source byte count of the longest stroke
	localparam int CNT_W = WIDTH_COUNT_BITS;

	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_NIBBLE_MODE  = 2'd0;
	localparam logic [1:0] REG_START_PHASE  = 2'd1;
	localparam logic [1:0] REG_WIDTH_PIXELS = 2'd2;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);

	// configuration seen by the front end
	typedef struct packed {
		logic        nibble_mode;
		logic [2:0]  start_phase;
		logic [15:0] width_pixels;
		logic        restart;      // one-cycle pulse on a register write
	} bosr_cfg_t;

	// one queue entry: one or two output bytes produced by one source byte
	typedef struct packed {
		logic [7:0] r0_byte;
		logic       r0_last;
		logic       has_r1;       // a second byte (always the last) follows
		logic [7:0] r1_byte;
	} bosr_entry_t;

	typedef enum logic {
		PH_FIRST,
		PH_SECOND
	} bosr_phase_t;

endpackage

/* rtl/core/bosr_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bosr_cfg - APB register file
// Holds nibble_mode, start_phase, width_pixels; flags a stroke restart.
// ----------------------------------------------------------------------------
module bosr_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bosr_pkg::APB_AW-1:0] paddr,
	input  logic [bosr_pkg::APB_DW-1:0] pwdata,
	output logic [bosr_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	output bosr_pkg::bosr_cfg_t         cfg
);
	import bosr_pkg::*;

	logic        nibble_mode_q;
	logic [2:0]  start_phase_q;
	logic [15:0] width_pixels_q;
	logic        restart_q;
	logic        wr_en;
	logic [1:0]  idx;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nibble_mode_q  <= 1'b0;
			start_phase_q  <= 3'd0;
			width_pixels_q <= 16'd1;
			restart_q      <= 1'b0;
		end else begin
			restart_q <= 1'b0;
			if (wr_en) begin
				case (idx)
					REG_NIBBLE_MODE: begin
						nibble_mode_q <= pwdata[0];
						restart_q     <= 1'b1;
					end
					REG_START_PHASE: begin
						start_phase_q <= pwdata[2:0];
						restart_q     <= 1'b1;
					end
					REG_WIDTH_PIXELS: begin
						width_pixels_q <= pwdata[15:0];
						restart_q      <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		case (idx)
			REG_NIBBLE_MODE:  prdata = APB_DW'(nibble_mode_q);
			REG_START_PHASE:  prdata = APB_DW'(start_phase_q);
			REG_WIDTH_PIXELS: prdata = APB_DW'(width_pixels_q);
			default:          prdata = '0;
		endcase
	end

	assign cfg.nibble_mode  = nibble_mode_q;
	assign cfg.start_phase  = start_phase_q;
	assign cfg.width_pixels = width_pixels_q;
	assign cfg.restart      = restart_q;

	// a restart pulse only follows a write to a defined register
	a_restart_src: assert property (@(posedge clk) disable iff (!arst_n)
		restart_q |-> $past(wr_en) && ($past(idx) != 2'd3))
		else $error("restart without a register write");
	a_restart_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		restart_q && !$past(wr_en, 2) |=> !restart_q || $past(wr_en))
		else $error("restart pulse stretched");
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

/* rtl/core/bosr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bosr_front - source byte intake and classification
// Tracks the stroke position and turns each source byte into a queue entry.
// ----------------------------------------------------------------------------
module bosr_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bosr_pkg::bosr_cfg_t   cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            in_byte,
	input  logic                  q_full,
	output logic                  q_push,
	output bosr_pkg::bosr_entry_t q_entry
);
	import bosr_pkg::*;

	logic [CNT_W-1:0]  taken_q;
	logic [7:0]        held_q;

	logic [2:0]        sh;
	logic [CNT_W-1:0]  w;
	logic [BITS_W-1:0] bits;
	logic [BITS_W:0]   sum_out;
	logic [BITS_W:0]   sum_src;
	logic [CNT_W-1:0]  n_out;
	logic [CNT_W-1:0]  n_src;
	logic [CNT_W:0]    t_plus1;
	logic [15:0]       pair;
	logic [7:0]        merged;
	logic [7:0]        tail;
	logic              merge_en;
	logic              merge_last;
	logic              tail_en;
	logic              has_out;
	logic              done;
	logic              accept;

	assign sh = cfg.nibble_mode ? {cfg.start_phase[0], 2'b00} : cfg.start_phase;
	assign w  = CNT_W'(cfg.width_pixels);
	assign bits = cfg.nibble_mode ? {w, 2'b00} : BITS_W'(w);

	assign sum_out = {1'b0, bits} + (BITS_W+1)'(7);
	assign sum_src = {1'b0, bits} + (BITS_W+1)'(sh) + (BITS_W+1)'(7);
	assign n_out   = CNT_W'(sum_out >> 3);
	assign n_src   = CNT_W'(sum_src >> 3);
	assign t_plus1 = {1'b0, taken_q} + (CNT_W+1)'(1);

	// funnel: top byte of {held, next} shifted left by the bit offset
	assign pair   = {held_q, in_byte} << sh;
	assign merged = pair[15:8];
	assign tail   = in_byte << sh;

	always_comb begin
		q_entry    = '0;
		merge_en   = 1'b0;
		merge_last = 1'b0;
		tail_en    = 1'b0;
		has_out    = 1'b0;
		done       = 1'b0;
		if (sh == 3'd0) begin
			q_entry.r0_byte = in_byte;
			q_entry.r0_last = (t_plus1 >= {1'b0, n_out});
			has_out         = 1'b1;
			done            = q_entry.r0_last;
		end else begin
			merge_en   = (taken_q != '0);
			merge_last = merge_en && (taken_q >= n_out);
			tail_en    = !merge_last && (t_plus1 >= {1'b0, n_src}) && (n_src == n_out);
			if (merge_en) begin
				q_entry.r0_byte = merged;
				q_entry.r0_last = merge_last;
				q_entry.has_r1  = tail_en;
				q_entry.r1_byte = tail;
			end else begin
				q_entry.r0_byte = tail;
				q_entry.r0_last = 1'b1;
			end
			has_out = merge_en || tail_en;
			done    = merge_last || tail_en;
		end
	end

	// hold off intake while the stroke position is being cleared
	assign in_ready = !q_full && !cfg.restart;
	assign accept   = in_valid && in_ready && (n_out != '0);
	assign q_push   = accept && has_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= '0;
			held_q  <= '0;
		end else if (cfg.restart) begin
			taken_q <= '0;
			held_q  <= '0;
		end else if (accept) begin
			held_q  <= in_byte;
			taken_q <= done ? '0 : CNT_W'(t_plus1);
		end
	end

	// the stroke always ends before the source count is passed
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(!cfg.restart && (n_out != '0)) |-> (taken_q <= n_src))
		else $error("stroke position past the source byte count");
	a_push_ready: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("push into a full queue");
	a_restart_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.restart |=> (taken_q == '0))
		else $error("stroke position not cleared by a register write");

endmodule

/* rtl/core/bosr_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bosr_queue - short entry queue between front and back end
// Four-entry FIFO; head entry is visible without a pop.
// ----------------------------------------------------------------------------
module bosr_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  bosr_pkg::bosr_entry_t push_entry,
	output logic                  full,
	input  logic                  pop,
	output logic                  empty,
	output bosr_pkg::bosr_entry_t head
);
	import bosr_pkg::*;

	bosr_entry_t        mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign full  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (FIFO_AW+1)'(1);
				2'b01:   count_q <= count_q - (FIFO_AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from an empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (FIFO_AW+1)'(FIFO_DEPTH))
		else $error("queue count overflow");
	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q - rd_ptr_q) == FIFO_AW'(count_q))
		else $error("queue pointers disagree with count");

endmodule

/* rtl/core/bosr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bosr_back - output sequencer
// Sends one or two bytes per queue entry on the output stream.
// ----------------------------------------------------------------------------
module bosr_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  bosr_pkg::bosr_entry_t q_head,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_byte,
	output logic                  out_last
);
	import bosr_pkg::*;

	bosr_phase_t phase_q;
	bosr_phase_t phase_nxt;
	logic        xfer;

	assign out_valid = !q_empty;
	assign xfer      = out_valid && out_ready;

	always_comb begin
		phase_nxt = phase_q;
		case (phase_q)
			PH_FIRST:  if (xfer && q_head.has_r1) phase_nxt = PH_SECOND;
			PH_SECOND: if (xfer) phase_nxt = PH_FIRST;
			default:   phase_nxt = PH_FIRST;
		endcase
	end

	always_comb begin
		case (phase_q)
			PH_FIRST: begin
				out_byte = q_head.r0_byte;
				out_last = q_head.r0_last;
				q_pop    = xfer && !q_head.has_r1;
			end
			PH_SECOND: begin
				out_byte = q_head.r1_byte;
				out_last = 1'b1;
				q_pop    = xfer;
			end
			default: begin
				out_byte = q_head.r0_byte;
				out_last = q_head.r0_last;
				q_pop    = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
		end else begin
			phase_q <= phase_nxt;
		end
	end

	a_second_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SECOND) |-> !q_empty && q_head.has_r1)
		else $error("second byte sequenced without a two-byte entry");
	a_second_last: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_FIRST) && xfer && q_head.has_r1 |-> !out_last)
		else $error("first of two bytes marked last");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(phase_q))
		else $error("sequencer advanced while stalled");

endmodule

/* rtl/core/bit_offset_stroke_realigner.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_offset_stroke_realigner - packed pixel stroke realigner
// Funnel-shifts a stroke of 1-bit or 4-bit pixels so its first pixel lands
// at bit 7 of output byte 0; emits ceil(width*bpp/8) bytes, last marked.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                          transaction when
//  --------  ---  -------------------------------  ------------------------
//  s_axis    in   tdata[7:0] = src_byte            tvalid & tready
//  m_axis    out  tdata[7:0] = out_byte, tlast     tvalid & tready
//  apb       in   nibble_mode @0x0, start_phase    psel & penable & pwrite
//                 @0x4, width_pixels @0x8
//
// Flow: one source byte per cycle while s_axis_tready is high; the front
// end classifies it in the cycle it is taken and queues an entry if it
// yields output; the back end drains one output byte per cycle while
// m_axis_tready is high. The last source byte can carry two output bytes.
// Reset clears the stroke position, the queue and the output sequencer;
// registers come up as 1-bit mode, zero phase, width 1.
// s_axis_tready drops when the 4-entry queue is full and in the cycle
// after a register write, while the stroke restarts; a stalled m_axis
// leaves the front end running until the queue fills.
//
module bit_offset_stroke_realigner (
	input  logic                        clk,
	input  logic                        arst_n,
	// source stream
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [7:0]                  s_axis_tdata,   // [7:0] src_byte
	// realigned stream
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [7:0]                  m_axis_tdata,   // [7:0] out_byte
	output logic                        m_axis_tlast,   // out_last
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bosr_pkg::APB_AW-1:0] paddr,
	input  logic [bosr_pkg::APB_DW-1:0] pwdata,
	output logic [bosr_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);
	import bosr_pkg::*;

	bosr_cfg_t   cfg;
	bosr_entry_t push_entry;
	bosr_entry_t head;
	logic        q_push;
	logic        q_pop;
	logic        q_full;
	logic        q_empty;

	// register file; a write pulses cfg.restart
	bosr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// front end: stroke position, held byte, funnel shift
	bosr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (push_entry)
	);

	// decoupling queue
	bosr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.empty      (q_empty),
		.head       (head)
	);

	// back end: splits two-byte entries onto the output stream
	bosr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (head),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule
